### hdl/assert_macros.svh
// Assertion macros for the RTL file that carries checks.
// Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property checked at every rising edge, switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");

// An implication checked in the same cycle, switched off while reset is held.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/lcmw_pkg.sv
`default_nettype none

package lcmw_pkg;

    // Field widths, fixed by the channel formats.
    localparam int SAMPLE_BITS   = 24;
    localparam int DELTA_BITS    = 25;
    localparam int MAG_BITS      = 24;
    localparam int SCALE_BITS    = 24;
    localparam int PROD_BITS     = MAG_BITS + SCALE_BITS;
    localparam int TENTHS_BITS   = 28;
    localparam int WHOLE_BITS    = 24;
    localparam int DIGIT_BITS    = 4;
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 24;

    // Default group length.
    localparam int GROUP_SIZE_DEF = 5;

    // The scale factor is a Q0.24 fraction; rounding adds one half before the shift.
    localparam int SCALE_FRAC = 24;

    // Division by ten of a tenths count: multiply by ceil(2^35 / 10), keep bits 35 and up.
    // Exact for every value below 2^34, which covers the whole tenths range.
    localparam int                RECIP_SHIFT = 35;
    localparam int                RECIP_BITS  = 32;
    localparam logic [RECIP_BITS-1:0] RECIP10 = 32'd3435973837;

    localparam logic [DIGIT_BITS-1:0] DIGIT_BASE = 4'd10;

    typedef logic signed [SAMPLE_BITS-1:0] lcmw_sample_t;

    // Register map of the configuration port.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_TARE_OFFSET = 8'd0,
        REG_SCALE_Q24   = 8'd1
    } lcmw_reg_t;

    localparam lcmw_sample_t            TARE_RESET  = 24'sd116876;
    localparam logic [SCALE_BITS-1:0]   SCALE_RESET = 24'd41976;

    // Live configuration, handed to the datapath.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] tare;
        logic [SCALE_BITS-1:0]         scale;
    } lcmw_cfg_t;

    // Status of the group register toward the median stage.
    typedef struct packed {
        logic valid;
        logic timed_out;
    } lcmw_ctl_t;

    // Median stage word toward the weighing pipeline.
    typedef struct packed {
        logic         timed_out;
        lcmw_sample_t med;
    } lcmw_med_t;

endpackage

`default_nettype wire

### hdl/lcmw_if.sv
`default_nettype none

// Sample channel: one converter reading per word.
interface lcmw_in_if;
    import lcmw_pkg::*;

    logic         valid;
    logic         ready;
    lcmw_sample_t sample;
    logic         timeout;

    modport source (output valid, sample, timeout, input ready);
    modport sink (input valid, sample, timeout, output ready);
endinterface

// Result channel: one weighed group per word.
interface lcmw_out_if;
    import lcmw_pkg::*;

    logic                          valid;
    logic                          ready;
    lcmw_sample_t                  median_raw;
    logic signed [DELTA_BITS-1:0]  delta;
    logic [TENTHS_BITS-1:0]        weight_tenths;
    logic [WHOLE_BITS-1:0]         grams_whole;
    logic [DIGIT_BITS-1:0]         grams_tenth;
    logic                          timed_out;

    modport source (output valid, median_raw, delta, weight_tenths, grams_whole,
                    grams_tenth, timed_out, input ready);
    modport sink (input valid, median_raw, delta, weight_tenths, grams_whole,
                  grams_tenth, timed_out, output ready);
endinterface

// Configuration write channel.
interface lcmw_cfg_if;
    import lcmw_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

### hdl/lcmw_window.sv
`default_nettype none

module lcmw_window #(
    parameter int GROUP_SIZE = lcmw_pkg::GROUP_SIZE_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    lcmw_in_if.sink                samples,
    output lcmw_pkg::lcmw_sample_t grp [GROUP_SIZE],
    output lcmw_pkg::lcmw_ctl_t    grp_ctl,
    input  wire logic              grp_ready
);
    import lcmw_pkg::*;

    localparam int               CNT_W = $clog2(GROUP_SIZE);
    localparam logic [CNT_W-1:0] LAST  = CNT_W'(GROUP_SIZE - 1);

    lcmw_sample_t     win_reg [GROUP_SIZE-1];
    lcmw_sample_t     grp_reg [GROUP_SIZE];
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             valid_reg;
    logic             valid_next;
    logic             to_reg;
    logic             take;
    logic             done;

    // The group register may be refilled in the cycle it is drained.
    assign samples.ready = !valid_reg || grp_ready;
    assign take          = samples.valid && samples.ready;
    assign done          = take && (samples.timeout || (fill_reg == LAST));

    always_comb
    begin
        fill_next = fill_reg;
        if (done)
        begin
            fill_next = '0;
        end
        else if (take)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (done)
        begin
            valid_next = 1'b1;
        end
        else if (grp_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg  <= fill_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < GROUP_SIZE - 1; i++)
        begin
            if (take && !samples.timeout && (fill_reg == CNT_W'(i)))
            begin
                win_reg[i] <= samples.sample;
            end
        end
        if (done)
        begin
            to_reg <= samples.timeout;
            for (int i = 0; i < GROUP_SIZE - 1; i++)
            begin
                grp_reg[i] <= win_reg[i];
            end
            grp_reg[GROUP_SIZE-1] <= samples.sample;
        end
    end

    assign grp               = grp_reg;
    assign grp_ctl.valid     = valid_reg;
    assign grp_ctl.timed_out = to_reg;

endmodule

`default_nettype wire

### hdl/lcmw_median.sv
`default_nettype none

module lcmw_median #(
    parameter int GROUP_SIZE = lcmw_pkg::GROUP_SIZE_DEF
) (
    input  wire lcmw_pkg::lcmw_sample_t smp [GROUP_SIZE],
    output lcmw_pkg::lcmw_sample_t      med
);
    import lcmw_pkg::*;

    localparam int               CNT_W = $clog2(GROUP_SIZE);
    localparam logic [CNT_W-1:0] MID   = CNT_W'(GROUP_SIZE / 2);

    logic [GROUP_SIZE-1:0] hit;

    // Each sample's place in a stable ascending sort: equal values keep their order,
    // so the places form a permutation and exactly one sample sits in the middle.
    for (genvar i = 0; i < GROUP_SIZE; i++)
    begin : g_rank
        logic [CNT_W-1:0] rank;

        always_comb
        begin
            rank = '0;
            for (int j = 0; j < GROUP_SIZE; j++)
            begin
                if (j < i)
                begin
                    if (smp[j] <= smp[i])
                    begin
                        rank = rank + CNT_W'(1);
                    end
                end
                else if (j > i)
                begin
                    if (smp[j] < smp[i])
                    begin
                        rank = rank + CNT_W'(1);
                    end
                end
            end
        end

        assign hit[i] = (rank == MID);
    end

    always_comb
    begin
        med = '0;
        for (int i = 0; i < GROUP_SIZE; i++)
        begin
            if (hit[i])
            begin
                med = med | smp[i];
            end
        end
    end

endmodule

`default_nettype wire

### hdl/lcmw_weigh.sv
`default_nettype none

module lcmw_weigh (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lcmw_pkg::lcmw_cfg_t cfg_val,
    input  wire logic                in_valid,
    input  wire lcmw_pkg::lcmw_med_t in_word,
    output logic                     in_ready,
    lcmw_out_if.source               weights
);
    import lcmw_pkg::*;

    localparam int WIDE_BITS = PROD_BITS + 4;
    localparam int RQ_BITS   = TENTHS_BITS + RECIP_BITS;
    localparam logic [WIDE_BITS-1:0] ROUND_HALF = WIDE_BITS'(1) << (SCALE_FRAC - 1);

    // Stage valids and the ready chain; a stage refills when empty or draining.
    logic c_valid_reg, d_valid_reg, e_valid_reg, f_valid_reg, o_valid_reg;
    logic c_ready, d_ready, e_ready, f_ready, o_ready;

    assign o_ready  = !o_valid_reg || weights.ready;
    assign f_ready  = !f_valid_reg || o_ready;
    assign e_ready  = !e_valid_reg || f_ready;
    assign d_ready  = !d_valid_reg || e_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign in_ready = c_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (c_ready)
            begin
                c_valid_reg <= in_valid;
            end
            if (d_ready)
            begin
                d_valid_reg <= c_valid_reg;
            end
            if (e_ready)
            begin
                e_valid_reg <= d_valid_reg;
            end
            if (f_ready)
            begin
                f_valid_reg <= e_valid_reg;
            end
            if (o_ready)
            begin
                o_valid_reg <= f_valid_reg;
            end
        end
    end

    // Tare subtraction and magnitude.
    logic signed [DELTA_BITS-1:0] delta_c;
    logic [MAG_BITS-1:0]          mag_c;

    assign delta_c = DELTA_BITS'(in_word.med) - DELTA_BITS'(cfg_val.tare);
    assign mag_c   = delta_c[DELTA_BITS-1] ? MAG_BITS'(-delta_c) : MAG_BITS'(delta_c);

    logic                         c_to_reg;
    lcmw_sample_t                 c_med_reg;
    logic signed [DELTA_BITS-1:0] c_delta_reg;
    logic [MAG_BITS-1:0]          c_mag_reg;

    always_ff @(posedge clk)
    begin
        if (c_ready && in_valid)
        begin
            c_to_reg    <= in_word.timed_out;
            c_med_reg   <= in_word.med;
            c_delta_reg <= in_word.timed_out ? '0 : delta_c;
            c_mag_reg   <= in_word.timed_out ? '0 : mag_c;
        end
    end

    // Magnitude times the Q0.24 scale.
    logic                         d_to_reg;
    lcmw_sample_t                 d_med_reg;
    logic signed [DELTA_BITS-1:0] d_delta_reg;
    logic [PROD_BITS-1:0]         d_prod_reg;

    always_ff @(posedge clk)
    begin
        if (d_ready && c_valid_reg)
        begin
            d_to_reg    <= c_to_reg;
            d_med_reg   <= c_med_reg;
            d_delta_reg <= c_delta_reg;
            d_prod_reg  <= PROD_BITS'(c_mag_reg) * PROD_BITS'(cfg_val.scale);
        end
    end

    // Times ten as two shifted adds, plus one half, then drop the fraction.
    logic [WIDE_BITS-1:0] times10_e;

    assign times10_e = (WIDE_BITS'(d_prod_reg) << 3) + (WIDE_BITS'(d_prod_reg) << 1)
                     + ROUND_HALF;

    logic                         e_to_reg;
    lcmw_sample_t                 e_med_reg;
    logic signed [DELTA_BITS-1:0] e_delta_reg;
    logic [TENTHS_BITS-1:0]       e_tenths_reg;

    always_ff @(posedge clk)
    begin
        if (e_ready && d_valid_reg)
        begin
            e_to_reg     <= d_to_reg;
            e_med_reg    <= d_med_reg;
            e_delta_reg  <= d_delta_reg;
            e_tenths_reg <= times10_e[SCALE_FRAC +: TENTHS_BITS];
        end
    end

    // Whole grams by reciprocal multiplication.
    logic [RQ_BITS-1:0] recip_f;

    assign recip_f = RQ_BITS'(e_tenths_reg) * RQ_BITS'(RECIP10);

    logic                         f_to_reg;
    lcmw_sample_t                 f_med_reg;
    logic signed [DELTA_BITS-1:0] f_delta_reg;
    logic [TENTHS_BITS-1:0]       f_tenths_reg;
    logic [WHOLE_BITS-1:0]        f_whole_reg;

    always_ff @(posedge clk)
    begin
        if (f_ready && e_valid_reg)
        begin
            f_to_reg     <= e_to_reg;
            f_med_reg    <= e_med_reg;
            f_delta_reg  <= e_delta_reg;
            f_tenths_reg <= e_tenths_reg;
            f_whole_reg  <= recip_f[RECIP_SHIFT +: WHOLE_BITS];
        end
    end

    // The tenth digit is what is left after taking ten times the whole grams.
    logic [WHOLE_BITS+3:0] ten_whole_o;
    logic [DIGIT_BITS-1:0] digit_o;

    assign ten_whole_o = ((WHOLE_BITS + 4)'(f_whole_reg) << 3)
                       + ((WHOLE_BITS + 4)'(f_whole_reg) << 1);
    assign digit_o     = f_tenths_reg[DIGIT_BITS-1:0] - ten_whole_o[DIGIT_BITS-1:0];

    logic                         o_to_reg;
    lcmw_sample_t                 o_med_reg;
    logic signed [DELTA_BITS-1:0] o_delta_reg;
    logic [TENTHS_BITS-1:0]       o_tenths_reg;
    logic [WHOLE_BITS-1:0]        o_whole_reg;
    logic [DIGIT_BITS-1:0]        o_digit_reg;

    always_ff @(posedge clk)
    begin
        if (o_ready && f_valid_reg)
        begin
            o_to_reg     <= f_to_reg;
            o_med_reg    <= f_med_reg;
            o_delta_reg  <= f_delta_reg;
            o_tenths_reg <= f_tenths_reg;
            o_whole_reg  <= f_whole_reg;
            o_digit_reg  <= digit_o;
        end
    end

    assign weights.valid         = o_valid_reg;
    assign weights.median_raw    = o_med_reg;
    assign weights.delta         = o_delta_reg;
    assign weights.weight_tenths = o_tenths_reg;
    assign weights.grams_whole   = o_whole_reg;
    assign weights.grams_tenth   = o_digit_reg;
    assign weights.timed_out     = o_to_reg;

endmodule

`default_nettype wire

### hdl/load_cell_median5_weigher.sv
// Channel   Dir  Handshake     Word contents
// samples   in   valid/ready   sample (24 bit signed), timeout
// weights   out  valid/ready   median_raw, delta, weight_tenths, grams_whole,
//                              grams_tenth, timed_out
// cfg       in   valid/ready   index (0 tare_offset, 1 scale_q24), wdata (24 bit)
//
// One sample word is accepted per cycle while the group register is empty or draining.
// The result word of a group, from the edge that accepts its last sample (or its timeout),
// runs through a chain of seven registered stages: group capture, median, tare, scale multiply,
// round, divide by ten, output register; each stage refills as its group moves on.
// Reset clears the fill count and all stage valids and loads the default tare and
// scale; there is no clearing pass. A stalled result holds only the stages behind
// it that are full, so empty stages keep taking samples.
`default_nettype none
`include "assert_macros.svh"

module load_cell_median5_weigher #(
    parameter int GROUP_SIZE = lcmw_pkg::GROUP_SIZE_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lcmw_in_if.sink     samples,
    lcmw_out_if.source  weights,
    lcmw_cfg_if.sink    cfg
);
    import lcmw_pkg::*;

    // Configuration registers. Writes are only issued while the block is idle (the user must
    // keep to this; the block does not enforce it), so every stage may read them directly.
    lcmw_cfg_t cfg_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tare  <= TARE_RESET;
            cfg_reg.scale <= SCALE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_TARE_OFFSET:
                begin
                    cfg_reg.tare <= $signed(cfg.wdata);
                end
                REG_SCALE_Q24:
                begin
                    cfg_reg.scale <= cfg.wdata;
                end
                default:
                begin
                    // Unmapped index: the write is dropped.
                end
            endcase
        end
    end

    // Sample window. It collects the group and, on the last sample or on a
    // timeout, hands a whole group to the median stage.
    lcmw_sample_t grp [GROUP_SIZE];
    lcmw_ctl_t    grp_ctl;
    logic         grp_ready;

    lcmw_window #(
        .GROUP_SIZE (GROUP_SIZE)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .grp       (grp),
        .grp_ctl   (grp_ctl),
        .grp_ready (grp_ready)
    );

    // Median selection over the captured group.
    lcmw_sample_t median_c;

    lcmw_median #(
        .GROUP_SIZE (GROUP_SIZE)
    ) u_median (
        .smp (grp),
        .med (median_c)
    );

    // Median stage register. A timeout word carries a zero median; the tare stage then
    // zeroes its delta and magnitude, so every field but timed_out comes out zero.
    logic      b_valid_reg;
    logic      b_valid_next;
    lcmw_med_t b_word_reg;
    logic      b_ready;
    logic      wgh_ready;

    assign b_ready   = !b_valid_reg || wgh_ready;
    assign grp_ready = b_ready;

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (b_ready)
        begin
            b_valid_next = grp_ctl.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && grp_ctl.valid)
        begin
            b_word_reg.timed_out <= grp_ctl.timed_out;
            b_word_reg.med       <= grp_ctl.timed_out ? '0 : median_c;
        end
    end

    // Tare, scale, rounding and the decimal split, ending in the output register.
    lcmw_weigh u_weigh (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_val  (cfg_reg),
        .in_valid (b_valid_reg),
        .in_word  (b_word_reg),
        .in_ready (wgh_ready),
        .weights  (weights)
    );

    // Whole grams and the tenth digit put back together, and the fields that a
    // timeout word must leave at zero.
    logic [TENTHS_BITS-1:0] tenths_rebuilt;
    logic                   timeout_clean;

    assign tenths_rebuilt = TENTHS_BITS'(weights.grams_whole) * TENTHS_BITS'(DIGIT_BASE)
                          + TENTHS_BITS'(weights.grams_tenth);
    assign timeout_clean  = (weights.weight_tenths == '0) && (weights.median_raw == '0)
                          && (weights.delta == '0);

    // The tenth digit is a single decimal digit.
    `ASSERT_IMPLY(a_digit_range, clk, rst_n, weights.valid, weights.grams_tenth < DIGIT_BASE)

    // Whole grams and the tenth digit put back together give the tenths count.
    `ASSERT_IMPLY(a_decimal_split, clk, rst_n, weights.valid, tenths_rebuilt == weights.weight_tenths)

    // A timeout word carries no weight, no median and no delta.
    `ASSERT_IMPLY(a_timeout_zero, clk, rst_n, weights.valid && weights.timed_out, timeout_clean)

endmodule

`default_nettype wire

### dv/lcmw_weigh_checker.sv
`timescale 1ns / 100ps

// Watches the three channels of the weigher, keeps its own copy of the
// configuration and of the group being filled, and compares every result word
// with the oldest prediction still waiting.
module lcmw_weigh_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    lcmw_in_if        samples,
    lcmw_out_if       weights,
    lcmw_cfg_if       cfg,
    output int        mismatches,
    output int        outstanding
);
    import lcmw_pkg::*;

    localparam int GROUP_LEN = GROUP_SIZE_DEF;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] median_raw;
        logic signed [DELTA_BITS-1:0]  delta;
        logic [TENTHS_BITS-1:0]        weight_tenths;
        logic [WHOLE_BITS-1:0]         grams_whole;
        logic [DIGIT_BITS-1:0]         grams_tenth;
        logic                          timed_out;
    } weighing_t;

    lcmw_sample_t          window [GROUP_LEN];
    int unsigned           held;
    lcmw_sample_t          tare;
    logic [SCALE_BITS-1:0] scale;
    weighing_t             pending_weighings [$];
    int                    errors = 0;

    assign mismatches = errors;

    // Median of the full window, less tare, scaled and rounded to tenths.
    function automatic weighing_t weigh_window();
        lcmw_sample_t    sorted [GROUP_LEN];
        lcmw_sample_t    swap;
        longint          diff;
        longint unsigned magnitude;
        longint unsigned tenths;
        weighing_t       w;
        for (int i = 0; i < GROUP_LEN; i++)
            sorted[i] = window[i];
        for (int i = 0; i < GROUP_LEN - 1; i++)
            for (int j = 0; j < GROUP_LEN - 1 - i; j++)
                if (sorted[j] > sorted[j+1])
                begin
                    swap        = sorted[j];
                    sorted[j]   = sorted[j+1];
                    sorted[j+1] = swap;
                end
        diff      = longint'(sorted[GROUP_LEN/2]) - longint'(tare);
        magnitude = (diff < 0) ? longint'(-diff) : longint'(diff);
        tenths    = (magnitude * longint'({1'b0, scale}) * longint'(DIGIT_BASE)
                     + (64'd1 << (SCALE_FRAC - 1))) >> SCALE_FRAC;
        w.median_raw    = sorted[GROUP_LEN/2];
        w.delta         = diff[DELTA_BITS-1:0];
        w.weight_tenths = tenths[TENTHS_BITS-1:0];
        w.grams_whole   = WHOLE_BITS'(tenths / DIGIT_BASE);
        w.grams_tenth   = DIGIT_BITS'(tenths % DIGIT_BASE);
        w.timed_out     = 1'b0;
        return w;
    endfunction

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        weighing_t want;
        weighing_t fresh;
        if (!rst_n)
        begin
            held  = 0;
            tare  = TARE_RESET;
            scale = SCALE_RESET;
            pending_weighings.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_TARE_OFFSET: tare  = cfg.wdata;
                    REG_SCALE_Q24:   scale = cfg.wdata;
                    default: ;
                endcase
            end

            // Compare before predicting, so a word never matches its own sample.
            if (weights.valid && weights.ready)
            begin
                if (pending_weighings.size() == 0)
                begin
                    $display("%0t: result word with none pending, got median %0d timed_out %0b",
                             $time, weights.median_raw, weights.timed_out);
                    errors++;
                end
                else
                begin
                    want = pending_weighings.pop_front();
                    check_field("median_raw", want.median_raw, weights.median_raw);
                    check_field("delta", want.delta, weights.delta);
                    check_field("weight_tenths", want.weight_tenths, weights.weight_tenths);
                    check_field("grams_whole", want.grams_whole, weights.grams_whole);
                    check_field("grams_tenth", want.grams_tenth, weights.grams_tenth);
                    check_field("timed_out", want.timed_out, weights.timed_out);
                end
            end

            if (samples.valid && samples.ready)
            begin
                if (samples.timeout)
                begin
                    held            = 0;
                    fresh           = '0;
                    fresh.timed_out = 1'b1;
                    pending_weighings.push_back(fresh);
                end
                else
                begin
                    window[held] = samples.sample;
                    held++;
                    if (held == GROUP_LEN)
                    begin
                        held = 0;
                        pending_weighings.push_back(weigh_window());
                    end
                end
            end

            outstanding <= pending_weighings.size();
        end
    end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

// Testbench top for the load-cell weigher. It drives sample words and register
// writes, stalls the result channel at random, and leaves all prediction and
// comparison to the checker that sits beside the block.
module tb;
    import lcmw_pkg::*;

    // Random words per configuration phase; eight phases make up the random run.
    localparam int PHASE_ITEMS  = 115;
    localparam int PHASES       = 8;
    // Quiet cycles after the last predicted word, before anything touches the registers.
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_GAP      = 17;
    // Hard stop, well beyond the slowest correct run.
    localparam longint WATCHDOG_NS = 2_000_000;

    localparam lcmw_sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam lcmw_sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [CFG_IDX_BITS-1:0]  TOP_INDEX = '1;
    localparam logic [SCALE_BITS-1:0]    SCALE_MAX = '1;

    // How the samples of one random group are spread.
    typedef enum int {SPREAD_WIDE, SPREAD_NEAR, SPREAD_EDGES, SPREAD_FLAT} spread_t;

    logic clk;
    logic rst_n;

    lcmw_in_if  samples ();
    lcmw_out_if weights ();
    lcmw_cfg_if cfg ();

    int           mismatches;
    int           outstanding;
    int           words_sent;
    bit           send_steady;
    bit           take_steady;
    lcmw_sample_t tare_now;

    load_cell_median5_weigher dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .weights (weights),
        .cfg     (cfg)
    );

    lcmw_weigh_checker weigh_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples),
        .weights     (weights),
        .cfg         (cfg),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(WATCHDOG_NS);
        $display("TEST FAILED");
        $finish;
    end

    // Idle cycles before the next word on one side. At least a quarter of the draws are
    // zero so that runs of back-to-back words occur even in a busy phase, and a
    // steady phase never idles at all.
    function automatic int next_gap(input bit steady);
        if (steady || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Result side: hold ready low for a drawn number of cycles, then keep it
    // high until one word has been taken.
    initial
    begin
        int stall;
        weights.ready = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            stall = next_gap(take_steady);
            if (stall != 0)
            begin
                weights.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            weights.ready <= 1'b1;
            do @(posedge clk); while (!weights.valid);
        end
    end

    // Offer one sample word after a drawn gap. Valid stays high on return; the
    // next call either keeps it up or drops it, so it is assigned once per step.
    // While valid is low the payload carries junk, which the block must ignore.
    task automatic send_word(input lcmw_sample_t value, input logic timed);
        int gap;
        gap = next_gap(send_steady);
        if (gap != 0)
        begin
            samples.valid   <= 1'b0;
            samples.sample  <= lcmw_sample_t'($urandom);
            samples.timeout <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        samples.valid   <= 1'b1;
        samples.sample  <= value;
        samples.timeout <= timed;
        do @(posedge clk); while (!samples.ready);
        words_sent++;
    endtask

    // A timeout word; its sample field is random since the block must drop it.
    task automatic send_timeout();
        send_word(lcmw_sample_t'($urandom), 1'b1);
    endtask

    // One register write. The cycle with valid low afterwards keeps two writes
    // from assigning valid twice in the same step.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] index,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.wdata <= data;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Let every predicted word come out, then give a partial group time to
    // settle before anything touches the registers.
    task automatic settle();
        samples.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Both registers, with a write to an unmapped index in between that the
    // block has to drop.
    task automatic configure(input lcmw_sample_t tare, input logic [SCALE_BITS-1:0] scale);
        write_reg(REG_TARE_OFFSET, tare);
        write_reg(CFG_IDX_BITS'($urandom_range(int'(REG_SCALE_Q24) + 1, int'(TOP_INDEX))),
                  CFG_DATA_BITS'($urandom));
        write_reg(REG_SCALE_Q24, scale);
        tare_now = tare;
    endtask

    // Mostly complete groups with random content; one in twelve is cut short
    // by a timeout after zero to four samples.
    task automatic send_group();
        spread_t      spread;
        bit           broken;
        int           count;
        lcmw_sample_t base;
        lcmw_sample_t value;
        broken = ($urandom_range(0, 11) == 0);
        count  = broken ? $urandom_range(0, GROUP_SIZE_DEF - 1) : GROUP_SIZE_DEF;
        spread = spread_t'($urandom_range(int'(SPREAD_WIDE), int'(SPREAD_FLAT)));
        base   = $urandom_range(0, 1) ? tare_now : lcmw_sample_t'($urandom);
        for (int i = 0; i < count; i++)
        begin
            case (spread)
                SPREAD_WIDE: value = lcmw_sample_t'($urandom);
                SPREAD_NEAR: value = base + lcmw_sample_t'($urandom_range(0, 2047)) - 24'sd1024;
                SPREAD_EDGES:
                    case ($urandom_range(0, 4))
                        0:       value = SAMPLE_MIN;
                        1:       value = SAMPLE_MAX;
                        2:       value = '0;
                        3:       value = '1;
                        default: value = base;
                    endcase
                default:     value = base;
            endcase
            send_word(value, 1'b0);
        end
        if (broken)
            send_timeout();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        send_steady     = 1'b0;
        take_steady     = 1'b0;
        words_sent      = 0;
        tare_now        = TARE_RESET;
        samples.valid   = 1'b0;
        samples.sample  = '0;
        samples.timeout = 1'b0;
        cfg.valid       = 1'b0;
        cfg.index       = '0;
        cfg.wdata       = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A write to the highest index must leave the reset tare and scale alone.
        write_reg(TOP_INDEX, '1);

        // Directed words under the reset settings. A full group at the top of
        // the range, a timeout on an empty group, a timeout after three
        // samples, a full group at the bottom, a timeout after four, and an
        // unsorted group whose median equals the tare so the weight is zero.
        repeat (GROUP_SIZE_DEF) send_word(SAMPLE_MAX, 1'b0);
        send_word(SAMPLE_MAX, 1'b1);
        send_word(SAMPLE_MIN, 1'b0);
        send_word('0, 1'b0);
        send_word(SAMPLE_MAX, 1'b0);
        send_timeout();
        repeat (GROUP_SIZE_DEF) send_word(SAMPLE_MIN, 1'b0);
        send_word(24'sd12, 1'b0);
        send_word(-24'sd7, 1'b0);
        send_word(SAMPLE_MAX, 1'b0);
        send_word(SAMPLE_MIN, 1'b0);
        send_timeout();
        send_word(24'sd300000, 1'b0);
        send_word(-24'sd5, 1'b0);
        send_word(TARE_RESET, 1'b0);
        send_word(SAMPLE_MAX, 1'b0);
        send_word(SAMPLE_MIN, 1'b0);
        settle();

        // Random phases. The first keeps the reset settings; the others run
        // through the extremes of tare and scale, two random settings, and a
        // final write back to the reset values.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       ;
                1:       configure(SAMPLE_MIN, SCALE_MAX);
                2:       configure(SAMPLE_MAX, SCALE_MAX);
                3:       configure('0, '0);
                4:       configure('1, SCALE_BITS'(1));
                5, 6:    configure(lcmw_sample_t'($urandom), SCALE_BITS'($urandom));
                default: configure(TARE_RESET, SCALE_RESET);
            endcase
            send_steady = ($urandom_range(0, 3) == 0);
            take_steady = ($urandom_range(0, 3) == 0);
            words_sent  = 0;
            while (words_sent < PHASE_ITEMS)
                send_group();
            settle();
        end

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
